// ----- rtl/core/avdlf_pkg.sv -----
// package for the av1 deblocking line filter
// types, codes and filter tap tables; no dependencies
package avdlf_pkg;

  typedef enum logic [2:0] {
    MODE_MASKED   = 3'd0,
    MODE_NARROW_H = 3'd1,
    MODE_NARROW   = 3'd2,
    MODE_SIX      = 3'd3,
    MODE_EIGHT    = 3'd4,
    MODE_SIXTEEN  = 3'd5
  } mode_e;

  localparam logic [1:0] SIZE_4   = 2'd0;
  localparam logic [1:0] SIZE_8   = 2'd1;
  localparam logic [1:0] SIZE_16  = 2'd2;
  localparam logic [1:0] SIZE_BAD = 2'd3;

  localparam logic [0:0] REG_BIT_DEPTH = 1'b0;

  typedef struct packed {
    logic [5:0]  hev_thresh;
    logic [7:0]  edge_blimit;
    logic [5:0]  edge_limit;
    logic        is_chroma;
    logic [1:0]  size_code;
    logic [35:0] q_far;
    logic [47:0] q_near;
    logic [35:0] p_far;
    logic [47:0] p_near;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [2:0]  applied_mode;
    logic [35:0] out_q_far;
    logic [35:0] out_q_near;
    logic [35:0] out_p_far;
    logic [35:0] out_p_near;
  } rsp_t;

  // sixteen-wide taps, index 0..6 = p6..p0, 7..13 = q0..q6
  function automatic logic [2:0] tap16(input int r, input int k);
    logic [2:0] t [12][14];
    t = '{
      '{7,2,2,1,1,1,1,1,0,0,0,0,0,0}, '{5,2,2,2,1,1,1,1,1,0,0,0,0,0},
      '{4,1,2,2,2,1,1,1,1,1,0,0,0,0}, '{3,1,1,2,2,2,1,1,1,1,1,0,0,0},
      '{2,1,1,1,2,2,2,1,1,1,1,1,0,0}, '{1,1,1,1,1,2,2,2,1,1,1,1,1,0},
      '{0,1,1,1,1,1,2,2,2,1,1,1,1,1}, '{0,0,1,1,1,1,1,2,2,2,1,1,1,2},
      '{0,0,0,1,1,1,1,1,2,2,2,1,1,3}, '{0,0,0,0,1,1,1,1,1,2,2,2,1,4},
      '{0,0,0,0,0,1,1,1,1,1,2,2,2,5}, '{0,0,0,0,0,0,1,1,1,1,1,2,2,7}};
    return t[r][k];
  endfunction

  function automatic logic [1:0] tap8(input int r, input int k);
    logic [1:0] t [6][14];
    t = '{
      '{0,0,0,3,2,1,1,1,0,0,0,0,0,0}, '{0,0,0,2,1,2,1,1,1,0,0,0,0,0},
      '{0,0,0,1,1,1,2,1,1,1,0,0,0,0}, '{0,0,0,0,1,1,1,2,1,1,1,0,0,0},
      '{0,0,0,0,0,1,1,1,2,1,2,0,0,0}, '{0,0,0,0,0,0,1,1,1,2,3,0,0,0}};
    return t[r][k];
  endfunction

  function automatic logic [1:0] tap6(input int r, input int k);
    logic [1:0] t [4][14];
    t = '{
      '{0,0,0,0,3,2,2,1,0,0,0,0,0,0}, '{0,0,0,0,1,2,2,2,1,0,0,0,0,0},
      '{0,0,0,0,0,1,2,2,2,1,0,0,0,0}, '{0,0,0,0,0,0,1,2,2,3,0,0,0,0}};
    return t[r][k];
  endfunction

  function automatic logic [11:0] absd(input logic [11:0] a, input logic [11:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

endpackage

// ----- rtl/core/av1_deblock_line_filter.sv -----
// av1 deblocking filter for one sample line across a block edge
// an accepted request reaches the result register in the next cycle; one request per cycle unless the output stalls
// the result register advances whenever it is empty or being taken
// rst_ni clears the result valid flag and sets bit depth to 8
// depends on avdlf_pkg
module av1_deblock_line_filter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  avdlf_pkg::req_t     in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output avdlf_pkg::rsp_t     out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [0:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import avdlf_pkg::*;

  logic [3:0] bit_depth_q;
  logic       out_valid_q;
  rsp_t       rsp_q, rsp_d;

  // configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_depth_q <= 4'd8;
    end else if (psel && penable && pwrite && paddr == REG_BIT_DEPTH) begin
      bit_depth_q <= pwdata[3:0];
    end
  end
  assign prdata = (paddr == REG_BIT_DEPTH) ? {28'd0, bit_depth_q} : 32'd0;

  // handshake
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      rsp_q <= rsp_d;
    end
  end

  // filter datapath
  logic [11:0] s [14];
  logic [11:0] r [14];
  logic [2:0]  sh;
  logic        bad, chroma, big, wide;
  logic [13:0] lim, thr, one;
  logic [15:0] blim;
  logic        hev, mask, flat, flat2;
  logic [11:0] d_p10, d_q10;
  logic [14:0] bsum;
  logic [17:0] acc16 [12];
  logic [16:0] acc8 [6];
  logic [16:0] acc6 [4];
  logic signed [13:0] off, hi, lo, ps1, ps0, qs0, qs1;
  logic signed [15:0] f, fa, f1, f2, fb;
  mode_e mode;

  function automatic logic signed [15:0] clampv(input logic signed [15:0] v,
                                                input logic signed [13:0] l,
                                                input logic signed [13:0] h);
    if (v < 16'(l)) return 16'(l);
    if (v > 16'(h)) return 16'(h);
    return v;
  endfunction

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      s[6-i] = in_data_i.p_near[12*i +: 12];
      s[7+i] = in_data_i.q_near[12*i +: 12];
    end
    for (int i = 0; i < 3; i++) begin
      s[2-i]  = in_data_i.p_far[12*i +: 12];
      s[11+i] = in_data_i.q_far[12*i +: 12];
    end
    bad = in_data_i.size_code == SIZE_BAD ||
          !(bit_depth_q == 4'd8 || bit_depth_q == 4'd10 || bit_depth_q == 4'd12);
    // limit scaling is bit depth minus 8
    sh = (bit_depth_q == 4'd12) ? 3'd4 : (bit_depth_q == 4'd10) ? 3'd2 : 3'd0;
    chroma = in_data_i.is_chroma;
    big  = in_data_i.size_code != SIZE_4;
    wide = big && !chroma;
    lim  = 14'(in_data_i.edge_limit) << sh;
    thr  = 14'(in_data_i.hev_thresh) << sh;
    blim = 16'(in_data_i.edge_blimit) << sh;
    one  = 14'd1 << sh;
    d_p10 = absd(s[5], s[6]);
    d_q10 = absd(s[8], s[7]);
    hev = 14'(d_p10) > thr || 14'(d_q10) > thr;
    bsum = {2'b0, absd(s[6], s[7]), 1'b0} + 15'(absd(s[5], s[8]) >> 1);
    mask = 14'(d_p10) > lim || 14'(d_q10) > lim || 16'(bsum) > blim;
    if (big) mask = mask || 14'(absd(s[4], s[5])) > lim || 14'(absd(s[9], s[8])) > lim;
    if (wide) mask = mask || 14'(absd(s[3], s[4])) > lim || 14'(absd(s[10], s[9])) > lim;
    flat = 14'(d_p10) <= one && 14'(d_q10) <= one &&
           14'(absd(s[4], s[6])) <= one && 14'(absd(s[9], s[7])) <= one;
    if (wide) flat = flat && 14'(absd(s[3], s[6])) <= one && 14'(absd(s[10], s[7])) <= one;
    flat2 = 1'b1;
    for (int i = 4; i < 7; i++)
      flat2 = flat2 && 14'(absd(s[6-i], s[6])) <= one && 14'(absd(s[7+i], s[7])) <= one;

    // smoothing sums
    for (int j = 0; j < 12; j++) begin
      acc16[j] = 18'd8;
      for (int k = 0; k < 14; k++) acc16[j] = acc16[j] + 18'(tap16(j, k)) * 18'(s[k]);
    end
    for (int j = 0; j < 6; j++) begin
      acc8[j] = 17'd4;
      for (int k = 0; k < 14; k++) acc8[j] = acc8[j] + 17'(tap8(j, k)) * 17'(s[k]);
    end
    for (int j = 0; j < 4; j++) begin
      acc6[j] = 17'd4;
      for (int k = 0; k < 14; k++) acc6[j] = acc6[j] + 17'(tap6(j, k)) * 17'(s[k]);
    end

    // narrow filter
    off = 14'sd128 <<< sh;
    hi  = (14'sd128 <<< sh) - 14'sd1;
    lo  = -hi - 14'sd1;
    ps1 = $signed({2'b0, s[5]}) - off;
    ps0 = $signed({2'b0, s[6]}) - off;
    qs0 = $signed({2'b0, s[7]}) - off;
    qs1 = $signed({2'b0, s[8]}) - off;
    fa = hev ? clampv(16'(ps1) - 16'(qs1), lo, hi) : 16'sd0;
    f  = clampv(fa + 16'sd3 * (16'(qs0) - 16'(ps0)), lo, hi);
    f1 = clampv(f + 16'sd4, lo, hi) >>> 3;
    f2 = clampv(f + 16'sd3, lo, hi) >>> 3;
    fb = (f1 + 16'sd1) >>> 1;

    r = s;
    mode = MODE_MASKED;
    if (!bad && !mask) begin
      if (big && flat) begin
        if (chroma) begin
          for (int j = 0; j < 4; j++) r[5+j] = acc6[j][14:3];
          mode = MODE_SIX;
        end else if (in_data_i.size_code == SIZE_16 && flat2) begin
          for (int j = 0; j < 12; j++) r[1+j] = acc16[j][15:4];
          mode = MODE_SIXTEEN;
        end else begin
          for (int j = 0; j < 6; j++) r[4+j] = acc8[j][14:3];
          mode = MODE_EIGHT;
        end
      end else begin
        r[7] = 12'(clampv(16'(qs0) - f1, lo, hi) + 16'(off));
        r[6] = 12'(clampv(16'(ps0) + f2, lo, hi) + 16'(off));
        if (!hev) begin
          r[8] = 12'(clampv(16'(qs1) - fb, lo, hi) + 16'(off));
          r[5] = 12'(clampv(16'(ps1) + fb, lo, hi) + 16'(off));
          mode = MODE_NARROW;
        end else begin
          mode = MODE_NARROW_H;
        end
      end
    end

    rsp_d.out_p_near   = {r[4], r[5], r[6]};
    rsp_d.out_p_far    = {r[1], r[2], r[3]};
    rsp_d.out_q_near   = {r[9], r[8], r[7]};
    rsp_d.out_q_far    = {r[12], r[11], r[10]};
    rsp_d.applied_mode = mode;
    rsp_d.status       = bad;
  end

  // checks
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");
  a_err_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status |-> out_data_o.applied_mode == MODE_MASKED)
    else $error("error result with a filter mode");
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted request left no result");

endmodule
